// ===== rtl/hftd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Huffman table-walk decoder.
// No dependencies; imported by the front, back and top-level modules.
package hftd_pkg;

  // Default sizes
  localparam int TREE_ENTRIES_DEF = 1024;
  localparam int WORD_BITS_DEF    = 32;

  // Internal node range
  localparam int NODE_MIN = 256;
  localparam int NODE_MAX = 511;

  // Input action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_WORD  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ROOT_NODE  = 1'b0;
  localparam logic CFG_BYTE_COUNT = 1'b1;

  // Command kinds carried through the queue
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_WORD
  } cmd_kind_t;

  // Command header (bitstream word travels beside it)
  typedef struct packed {
    cmd_kind_t   kind;
    logic [9:0]  addr;
    logic [15:0] value;
  } cmd_hdr_t;

  // One result item
  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_last;
    logic       block_done;
    logic       bad_node;
  } res_t;

endpackage

// ===== rtl/hftd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input items, drops no-op items, and queues commands.
// Depends on hftd_pkg.
module hftd_front import hftd_pkg::*; #(
  parameter int TREE_ENTRIES = TREE_ENTRIES_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [9:0]           in_tree_addr,
  input  logic signed [15:0]   in_tree_value,
  input  logic [WORD_BITS-1:0] in_bit_word,
  output logic                 q_valid,
  input  logic                 q_ready,
  output cmd_hdr_t             q_hdr,
  output logic [WORD_BITS-1:0] q_word
);

  localparam logic [1:0] QDEPTH = 2'd2;

  cmd_hdr_t             hdr_r  [2];
  logic [WORD_BITS-1:0] word_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;

  logic     keep;
  cmd_hdr_t hdr_in;
  logic     push, pop;

  // Classify: loads beyond the table and unused actions are dropped
  always_comb begin
    keep          = 1'b0;
    hdr_in.kind   = CMD_WORD;
    hdr_in.addr   = in_tree_addr;
    hdr_in.value  = in_tree_value;
    unique case (in_action)
      ACT_LOAD: begin
        hdr_in.kind = CMD_LOAD;
        keep        = (32'(in_tree_addr) < 32'(TREE_ENTRIES));
      end
      ACT_START: begin
        hdr_in.kind = CMD_START;
        keep        = 1'b1;
      end
      ACT_WORD: begin
        hdr_in.kind = CMD_WORD;
        keep        = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (count_r != QDEPTH);
  assign q_valid  = (count_r != 2'd0);
  assign q_hdr    = hdr_r[rd_ptr_r];
  assign q_word   = word_r[rd_ptr_r];

  assign push = in_valid && in_ready && keep;
  assign pop  = q_valid && q_ready;

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      hdr_r[wr_ptr_r]  <= hdr_in;
      word_r[wr_ptr_r] <= in_bit_word;
    end
  end

endmodule

// ===== rtl/hftd_back.sv =====
`timescale 1ns / 1ps
// Back end: tree table memory, bit-by-bit tree walker, result hold and
// output register. Depends on hftd_pkg.
module hftd_back import hftd_pkg::*; #(
  parameter int TREE_ENTRIES = TREE_ENTRIES_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  cmd_hdr_t             q_hdr,
  input  logic [WORD_BITS-1:0] q_word,
  input  logic [8:0]           root_node,
  input  logic [31:0]          byte_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  localparam int AW = $clog2(TREE_ENTRIES);
  localparam int PW = $clog2(WORD_BITS);
  localparam logic [PW-1:0] LAST_POS = PW'(WORD_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Node is unusable when outside the internal range or its children
  // fall past the end of the table
  function automatic logic node_bad(input logic [14:0] v);
    logic [15:0] child;
    child = {v, 1'b1};
    return (v < 15'(NODE_MIN)) || (v > 15'(NODE_MAX)) ||
           (32'(child) >= 32'(TREE_ENTRIES));
  endfunction

  state_t               state_r, state_nxt;
  logic [8:0]           cur_node_r, cur_node_nxt;
  logic [31:0]          bytes_left_r, bytes_left_nxt;
  logic                 err_r, err_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 bad_pend_r, bad_pend_nxt;
  logic                 hold_vld_r, hold_vld_nxt;
  res_t                 hold_r, hold_nxt;
  logic                 out_vld_r, out_vld_nxt;
  res_t                 out_r, out_nxt;

  // Table memory
  logic [15:0]   mem [TREE_ENTRIES];
  logic [15:0]   rdata_r;
  logic          mem_we, mem_re;
  logic [8:0]    rd_node;
  logic          rd_bit;
  logic [AW-1:0] rd_addr;

  logic          slot_free, gen, stall, push_mid, push_last;
  logic          is_node, leaf, badraw, end_word;
  logic [8:0]    node_next;
  logic [PW-1:0] pos_inc;
  res_t          new_res;

  assign rd_addr = AW'({rd_node, rd_bit});

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(q_hdr.addr)] <= q_hdr.value;
    if (mem_re) rdata_r <= mem[rd_addr];
  end

  // Entry decode: nonnegative and at least 256 is a node, anything else a leaf
  assign is_node   = !rdata_r[15] && (rdata_r[14:8] != 7'd0);
  assign leaf      = rd_vld_r && !is_node;
  assign badraw    = rd_vld_r && is_node && node_bad(rdata_r[14:0]);
  assign slot_free = !out_vld_r || out_ready;
  assign pos_inc   = pos_r + PW'(1);
  assign node_next = leaf ? root_node : rdata_r[8:0];
  assign end_word  = (leaf && (bytes_left_r == 32'd1)) || (pos_r == LAST_POS);

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    cur_node_nxt   = cur_node_r;
    bytes_left_nxt = bytes_left_r;
    err_nxt        = err_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    rd_vld_nxt     = rd_vld_r;
    bad_pend_nxt   = bad_pend_r;
    hold_vld_nxt   = hold_vld_r;
    hold_nxt       = hold_r;
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_node        = cur_node_r;
    rd_bit         = q_word[0];
    gen            = 1'b0;
    stall          = 1'b0;
    push_mid       = 1'b0;
    push_last      = 1'b0;
    new_res        = '0;

    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_hdr.kind)
            CMD_LOAD: mem_we = 1'b1;
            CMD_START: begin
              cur_node_nxt   = root_node;
              bytes_left_nxt = byte_count;
              err_nxt        = 1'b0;
            end
            CMD_WORD: begin
              // words outside an active block are dropped
              if (!err_r && (bytes_left_r != 32'd0)) begin
                word_nxt  = q_word;
                pos_nxt   = '0;
                state_nxt = ST_WALK;
                if (node_bad({6'd0, cur_node_r})) begin
                  bad_pend_nxt = 1'b1;
                end else begin
                  mem_re     = 1'b1;
                  rd_node    = cur_node_r;
                  rd_bit     = q_word[0];
                  rd_vld_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        // result produced this cycle
        if (bad_pend_r || badraw) begin
          gen              = 1'b1;
          new_res.bad_node = 1'b1;
        end else if (leaf) begin
          gen                = 1'b1;
          new_res.byte_val   = rdata_r[7:0];
          new_res.block_done = (bytes_left_r == 32'd1);
        end
        stall = gen && hold_vld_r && !slot_free;

        if (!stall) begin
          if (gen) begin
            push_mid     = hold_vld_r;
            hold_vld_nxt = 1'b1;
            hold_nxt     = new_res;
          end
          if (bad_pend_r || badraw) begin
            err_nxt        = 1'b1;
            bytes_left_nxt = '0;
            bad_pend_nxt   = 1'b0;
            rd_vld_nxt     = 1'b0;
            state_nxt      = ST_FLUSH;
          end else begin
            cur_node_nxt = node_next;
            if (leaf) bytes_left_nxt = bytes_left_r - 32'd1;
            if (end_word) begin
              rd_vld_nxt = 1'b0;
              state_nxt  = ST_FLUSH;
            end else begin
              pos_nxt = pos_inc;
              if (node_bad({6'd0, node_next})) begin
                rd_vld_nxt   = 1'b0;
                bad_pend_nxt = 1'b1;
              end else begin
                mem_re     = 1'b1;
                rd_node    = node_next;
                rd_bit     = word_r[pos_inc];
                rd_vld_nxt = 1'b1;
              end
            end
          end
        end
      end

      ST_FLUSH: begin
        // the held result is the last one of this word
        if (!hold_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          push_last    = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (push_mid || push_last) begin
      out_vld_nxt      = 1'b1;
      out_nxt          = hold_r;
      out_nxt.run_last = push_last;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_node_r   <= 9'(NODE_MIN);
      bytes_left_r <= '0;
      err_r        <= 1'b0;
      rd_vld_r     <= 1'b0;
      bad_pend_r   <= 1'b0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_node_r   <= cur_node_nxt;
      bytes_left_r <= bytes_left_nxt;
      err_r        <= err_nxt;
      rd_vld_r     <= rd_vld_nxt;
      bad_pend_r   <= bad_pend_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    word_r <= word_nxt;
    pos_r  <= pos_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

  // Checks
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !hold_vld_r && !rd_vld_r && !bad_pend_r)
    else $error("idle with walk state pending");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> (rd_vld_r != bad_pend_r))
    else $error("walk without exactly one pending read or error");

  a_err_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> bytes_left_r == 32'd0)
    else $error("error seen with bytes left");

  a_read_good_node: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> !node_bad({6'd0, rd_node}))
    else $error("table read from a bad node");

  a_err_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    push_last && hold_r.bad_node |-> err_r)
    else $error("error result without error flag");

endmodule

// ===== rtl/huffman_table_tree_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the Huffman table-walk decoder: configuration registers,
// front end and back end. Depends on hftd_pkg, hftd_front and hftd_back.
//
// Load the tree one entry per item (action 0), then send a start item
// (action 1), which takes root_node and byte_count from the configuration
// registers, then send bitstream words (action 2), consumed LSB first. Each
// bit walks one step; a leaf gives one result and restarts at the root; a
// node below 256, above 511 or past the table end gives one error result and
// ends the block. A two-entry queue in front of the walker takes up to two
// input items while the walker or the output stalls. Load and start items
// are handled in the walker's idle state. A word issues its first read there,
// walks its bits (up to WORD_BITS) while the output does not stall, each read
// addressed by the entry read before it through the single read port of the
// tree memory, then hands off its last result before the next item. The table
// has no reset; every entry a tree walk can reach must be loaded first.
module huffman_table_tree_decoder import hftd_pkg::*; #(
  parameter int TREE_ENTRIES = TREE_ENTRIES_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [9:0]           in_tree_addr,
  input  logic signed [15:0]   in_tree_value,
  input  logic [WORD_BITS-1:0] in_bit_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_block_done,
  output logic                 out_bad_node,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [8:0]           root_node_r;
  logic [31:0]          byte_count_r;
  logic                 q_valid, q_ready;
  cmd_hdr_t             q_hdr;
  logic [WORD_BITS-1:0] q_word;
  res_t                 out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_node_r  <= 9'(NODE_MIN);
      byte_count_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROOT_NODE:  root_node_r  <= cfg_data[8:0];
        CFG_BYTE_COUNT: byte_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hftd_front #(
    .TREE_ENTRIES (TREE_ENTRIES),
    .WORD_BITS    (WORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_tree_addr  (in_tree_addr),
    .in_tree_value (in_tree_value),
    .in_bit_word   (in_bit_word),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_hdr         (q_hdr),
    .q_word        (q_word)
  );

  hftd_back #(
    .TREE_ENTRIES (TREE_ENTRIES),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_hdr      (q_hdr),
    .q_word     (q_word),
    .root_node  (root_node_r),
    .byte_count (byte_count_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_byte       = out_res.byte_val;
  assign out_run_last   = out_res.run_last;
  assign out_block_done = out_res.block_done;
  assign out_bad_node   = out_res.bad_node;

endmodule

// ===== sim/huffman_table_tree_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for huffman_table_tree_decoder: a scoreboard walks
// its own copy of the tree for every accepted item and checks each decoded byte.
// Depends on hftd_pkg and the decoder RTL.
module huffman_table_tree_decoder_test;
  import hftd_pkg::*;

  localparam int TREE_ENTRIES = TREE_ENTRIES_DEF;
  localparam int WORD_BITS    = WORD_BITS_DEF;
  localparam logic [1:0] ACT_NOP = 2'd3;   // unused action code
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4 * (WORD_BITS + 2);
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 40;
  // Walks stay inside a window of low nodes plus the top node
  localparam int NODE_SPAN    = 32;
  localparam int NODE_TOP     = NODE_MIN + NODE_SPAN - 1;

  // Scoreboard: tree copy, walk state and the queue of decoded bytes to come
  class byte_tracker;
    logic [15:0] tree [TREE_ENTRIES];
    int unsigned node;
    int unsigned left;
    bit          halted;
    logic [8:0]  root_sel;
    logic [31:0] count_sel;
    res_t        expected_bytes [$];
    int          fails;

    function new();
      root_sel  = 9'(NODE_MIN);
      count_sel = 32'd1;
      node      = NODE_MIN;
      left      = 0;
      halted    = 1'b0;
      fails     = 0;
      foreach (tree[i]) tree[i] = '0;
    endfunction

    function bit node_bad(int unsigned n);
      return n < NODE_MIN || n > NODE_MAX || 2 * n + 1 >= TREE_ENTRIES;
    endfunction

    function bit block_live();
      return !halted && left != 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_ROOT_NODE) root_sel = data[8:0];
      else count_sel = data;
    endfunction

    // Apply one accepted item; returns how many bytes it adds
    function int take_item(logic [1:0] act, logic [9:0] addr, logic [15:0] val,
                           logic [WORD_BITS-1:0] word);
      res_t        r;
      int unsigned raw;
      int          first;
      bit          err;
      first = expected_bytes.size();
      case (act)
        ACT_LOAD: tree[addr] = val;
        ACT_START: begin
          node   = root_sel;
          left   = count_sel;
          halted = 1'b0;
        end
        ACT_WORD: begin
          for (int i = 0; i < WORD_BITS; i++) begin
            if (block_live()) begin
              err = node_bad(node);
              if (!err) begin
                raw = tree[2 * node + word[i]];
                if (raw >= NODE_MIN && raw < 32'h8000) begin
                  // internal node; pointers past the table abort the block
                  if (node_bad(raw)) err = 1'b1;
                  else node = raw;
                end else begin
                  // leaf, negative entries included
                  left--;
                  r = '0;
                  r.byte_val   = raw[7:0];
                  r.block_done = (left == 0);
                  expected_bytes.push_back(r);
                  node = root_sel;
                end
              end
              if (err) begin
                r = '0;
                r.bad_node = 1'b1;
                expected_bytes.push_back(r);
                halted = 1'b1;
                left   = 0;
              end
            end
          end
        end
        default: ;
      endcase
      // mark the last byte of this item
      if (expected_bytes.size() > first) begin
        r = expected_bytes.pop_back();
        r.run_last = 1'b1;
        expected_bytes.push_back(r);
      end
      return expected_bytes.size() - first;
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result item: out_byte %02h bad_node %0b",
               got.byte_val, got.bad_node);
        fails++;
      end else begin
        want = expected_bytes.pop_front();
        if (got.byte_val !== want.byte_val) begin
          $error("out_byte: expected %02h, got %02h", want.byte_val, got.byte_val);
          fails++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
          fails++;
        end
        if (got.block_done !== want.block_done) begin
          $error("block_done: expected %0b, got %0b", want.block_done, got.block_done);
          fails++;
        end
        if (got.bad_node !== want.bad_node) begin
          $error("bad_node: expected %0b, got %0b", want.bad_node, got.bad_node);
          fails++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_action;
  logic [9:0]           in_tree_addr;
  logic signed [15:0]   in_tree_value;
  logic [WORD_BITS-1:0] in_bit_word;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 out_run_last;
  logic                 out_block_done;
  logic                 out_bad_node;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [31:0]          cfg_data;

  byte_tracker sb = new();
  bit          steady = 1'b0;   // no idling on either side
  int          hold_seq = 0;    // bumped to request a long receiver hold-off
  int          item_results;
  int          cycle_count;

  huffman_table_tree_decoder #(
    .TREE_ENTRIES(TREE_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_tree_addr  (in_tree_addr),
    .in_tree_value (in_tree_value),
    .in_bit_word   (in_bit_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_block_done(out_block_done),
    .out_bad_node  (out_bad_node),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random table entry: leaf, negative leaf, internal node, or a bad pointer
  function automatic logic [15:0] tree_entry(int bad_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < bad_pct) return 16'($urandom_range(16'h7FFF, NODE_MAX + 1));
    else if (pick < bad_pct + 40) return 16'($urandom_range(NODE_TOP, NODE_MIN));
    else if (pick < bad_pct + 50) return 16'h8000 | 16'($urandom_range(16'h7FFF));
    else return 16'($urandom_range(NODE_MIN - 1));
  endfunction

  // Offer one item, wait for acceptance, then predict it
  task automatic send(logic [1:0] act, logic [9:0] addr, logic [15:0] val,
                      logic [WORD_BITS-1:0] word);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_tree_addr  <= addr;
    in_tree_value <= val;
    in_bit_word   <= word;
    do @(posedge clk); while (!in_ready);
    item_results = sb.take_item(act, addr, val, word);
  endtask

  // Both registers back to back; valid drops once at the end
  task automatic write_regs(logic [8:0] root, logic [31:0] count);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROOT_NODE;
    cfg_data  <= {23'd0, root};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_ROOT_NODE, {23'd0, root});
    cfg_index <= CFG_BYTE_COUNT;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_BYTE_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every pending byte, then let the walker go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: check accepted results, then pick the next ready
  initial begin : receiver
    res_t got;
    int   hold_seen;
    int   hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.byte_val   = out_byte;
        got.run_last   = out_run_last;
        got.block_done = out_block_done;
        got.bad_node   = out_bad_node;
        sb.match_result(got);
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 29;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("huffman_table_tree_decoder_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int         pick;
    int         useful;
    logic [1:0] act;
    logic [9:0] addr;
    in_valid      <= 1'b0;
    in_action     <= ACT_NOP;
    in_tree_addr  <= '0;
    in_tree_value <= '0;
    in_bit_word   <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_ROOT_NODE;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no block armed after reset; unused action
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '1);
    send(ACT_NOP, 10'($urandom()), 16'($urandom()), $urandom());

    // fill every entry a walk can reach: the node window and the top node
    for (int a = 2 * NODE_MIN; a < 2 * (NODE_TOP + 1); a++)
      send(ACT_LOAD, 10'(a), tree_entry(0), $urandom());
    send(ACT_LOAD, 10'(2 * NODE_MAX), tree_entry(0), $urandom());
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), tree_entry(0), $urandom());
    send(ACT_LOAD, 10'd0, 16'($urandom()), $urandom());

    // default registers: one byte, rest of the word and next word dropped
    send(ACT_START, 10'($urandom()), 16'($urandom()), $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '0);
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '1);

    // top root, endless count; root 511 has a leaf and a self loop
    settle();
    write_regs(9'(NODE_MAX), 32'hFFFF_FFFF);
    send(ACT_LOAD, 10'(2 * NODE_MAX), 16'hFF80, $urandom());
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), 16'(NODE_MAX), $urandom());
    send(ACT_START, 10'($urandom()), 16'($urandom()), $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '0);
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '1);
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), 32'hAAAA_AAAA);
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), 32'h5555_5555);

    // most negative leaf and the largest plain leaf
    send(ACT_LOAD, 10'(2 * NODE_MAX), 16'h8000, $urandom());
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), 16'(NODE_MIN - 1), $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), 32'h0000_FFFF);

    // pointer just past the node range aborts; later words are dropped
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), 16'h0202, $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), '1);
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), $urandom());

    // byte then the largest positive pointer in one word
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), 16'h7FFF, $urandom());
    send(ACT_START, 10'($urandom()), 16'($urandom()), $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), 32'hFFFF_FFFE);
    send(ACT_LOAD, 10'(2 * NODE_MAX), tree_entry(0), $urandom());
    send(ACT_LOAD, 10'(2 * NODE_MAX + 1), tree_entry(0), $urandom());

    // empty block: every word is ignored
    settle();
    write_regs(9'(NODE_MIN), 32'd0);
    send(ACT_START, 10'($urandom()), 16'($urandom()), $urandom());
    send(ACT_WORD, 10'($urandom()), 16'($urandom()), $urandom());

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: write_regs(9'(NODE_MIN), 32'd1);
        1: write_regs(9'(NODE_MAX), 32'hFFFF_FFFF);
        default: write_regs(9'($urandom_range(NODE_TOP, NODE_MIN)), $urandom_range(40, 2));
      endcase
      steady = (p == 3);
      if (p == 5) hold_seq++;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if ((!sb.block_live() && pick < 50) || pick < 8) act = ACT_START;
        else if (pick < 20) act = ACT_LOAD;
        else if (pick < 24) act = ACT_NOP;
        else act = ACT_WORD;
        addr = 10'($urandom_range(TREE_ENTRIES - 1));
        // half the loads land on entries that walks actually read
        if (act == ACT_LOAD && pick % 2 == 0)
          addr = 10'($urandom_range(2 * NODE_TOP + 1, 2 * NODE_MIN));
        if (act == ACT_LOAD && addr >= TREE_ENTRIES / 2)
          send(act, addr, tree_entry(10), $urandom());
        else
          send(act, addr, 16'($urandom()), $urandom());
        if ((act != ACT_WORD && act != ACT_NOP) || item_results > 0) useful++;
      end
    end
    steady = 1'b0;

    settle();
    if (sb.fails == 0)
      $display("huffman_table_tree_decoder_test: PASS");
    else
      $display("huffman_table_tree_decoder_test: FAIL");
    $finish;
  end

endmodule

// ===== huffman_table_tree_decoder.f =====
rtl/hftd_pkg.sv
rtl/hftd_front.sv
rtl/hftd_back.sv
rtl/huffman_table_tree_decoder.sv
sim/huffman_table_tree_decoder_test.sv
